// ===== hw/rtl/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg
// Shared widths, register indexes, divider lane type and saturation helpers
// for the barycentric texel address pipeline.
// ----------------------------------------------------------------------------
package bta_pkg;

    // field widths
    localparam int FRAG_W  = 12;   // fragment coordinate
    localparam int COORD_W = 16;   // vertex coordinate
    localparam int DIF_W   = 17;   // coordinate difference
    localparam int PROD_W  = 34;   // product of two differences
    localparam int NUM_W   = 35;   // edge function / area
    localparam int REM_W   = 36;   // divider partial remainder
    localparam int QUO_W   = 18;   // weight quotient magnitude
    localparam int W_W     = 18;   // signed Q2.16 weight
    localparam int UV_W    = 16;   // signed Q4.12 texture coordinate
    localparam int UVP_W   = 34;   // uv times weight
    localparam int SUM_W   = 36;   // sum of three uv products
    localparam int IDX_W   = 12;   // texel index
    localparam int WIN_W   = 12;   // window size register
    localparam int DIV_STEPS = QUO_W;

    // reset values and defaults
    localparam logic [WIN_W-1:0] WIN_W_RESET = 12'd800;
    localparam logic [WIN_W-1:0] WIN_H_RESET = 12'd600;
    localparam int TEX_WIDTH_DEF  = 64;
    localparam int TEX_HEIGHT_DEF = 64;

    // configuration register indexes
    typedef enum logic [3:0] {
        REG_VERTEX_A  = 4'd0,
        REG_VERTEX_B  = 4'd1,
        REG_VERTEX_C  = 4'd2,
        REG_UV_A      = 4'd3,
        REG_UV_B      = 4'd4,
        REG_UV_C      = 4'd5,
        REG_WIN_WIDTH = 4'd6,
        REG_WIN_HEIGHT = 4'd7
    } reg_index_t;

    // one lane of the restoring divider
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [1:0]       low;   // dividend bits still to be shifted in
    } div_lane_t;

    // one restoring step: shift in a dividend bit, trial subtract
    function automatic div_lane_t div_step(input div_lane_t lane,
                                           input logic [NUM_W-1:0] divisor);
        logic [REM_W-1:0] trial;
        logic             ge;
        div_lane_t        res;
        trial   = {lane.rem[REM_W-2:0], lane.low[1]};
        ge      = trial >= REM_W'(divisor);
        res.rem = ge ? trial - REM_W'(divisor) : trial;
        res.quo = {lane.quo[QUO_W-2:0], ge};
        res.low = {lane.low[0], 1'b0};
        return res;
    endfunction

    // sign and clip a weight quotient to Q2.16
    function automatic logic signed [W_W-1:0] sat_weight(input logic [QUO_W-1:0] qmag,
                                                         input logic neg,
                                                         input logic ovf);
        logic signed [W_W-1:0] res;
        if (ovf) begin
            res = neg ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
        end else if (!neg) begin
            res = qmag[QUO_W-1] ? {1'b0, {(W_W-1){1'b1}}} : $signed(qmag);
        end else if (qmag > {1'b1, {(QUO_W-1){1'b0}}}) begin
            res = {1'b1, {(W_W-1){1'b0}}};
        end else begin
            res = $signed(W_W'(-qmag));
        end
        return res;
    endfunction

    // clip the third weight to Q2.16
    function automatic logic signed [W_W-1:0] sat_gamma(input logic signed [W_W+1:0] g);
        logic signed [W_W-1:0] res;
        if (g > (W_W+2)'(131071)) begin
            res = {1'b0, {(W_W-1){1'b1}}};
        end else if (g < -(W_W+2)'(131072)) begin
            res = {1'b1, {(W_W-1){1'b0}}};
        end else begin
            res = W_W'(g);
        end
        return res;
    endfunction

    // drop 16 fraction bits toward zero and clip to Q4.12
    function automatic logic signed [UV_W-1:0] scale_uv(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-17:0] q;
        logic signed [UV_W-1:0]   res;
        q = (SUM_W-16)'(s >>> 16);
        if (s[SUM_W-1] && (s[15:0] != 16'd0)) begin
            q = q + (SUM_W-16)'(1);
        end
        if (q > (SUM_W-16)'(32767)) begin
            res = {1'b0, {(UV_W-1){1'b1}}};
        end else if (q < -(SUM_W-16)'(32768)) begin
            res = {1'b1, {(UV_W-1){1'b0}}};
        end else begin
            res = UV_W'(q);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/bta_div_step.sv =====
// ----------------------------------------------------------------------------
// bta_div_step
// One registered restoring-division step for the alpha and beta lanes.
// ----------------------------------------------------------------------------
module bta_div_step (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [bta_pkg::NUM_W-1:0]   divisor,
    input  bta_pkg::div_lane_t          lane_a_in,
    input  bta_pkg::div_lane_t          lane_b_in,
    output bta_pkg::div_lane_t          lane_a_out,
    output bta_pkg::div_lane_t          lane_b_out
);

    bta_pkg::div_lane_t lane_a_reg;
    bta_pkg::div_lane_t lane_b_reg;
    bta_pkg::div_lane_t lane_a_next;
    bta_pkg::div_lane_t lane_b_next;

    // trial subtract on both lanes
    always_comb begin
        lane_a_next = bta_pkg::div_step(lane_a_in, divisor);
        lane_b_next = bta_pkg::div_step(lane_b_in, divisor);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_a_reg <= lane_a_next;
            lane_b_reg <= lane_b_next;
        end
    end

    assign lane_a_out = lane_a_reg;
    assign lane_b_out = lane_b_reg;

endmodule

// ===== hw/rtl/barycentric_texel_address.sv =====
// ----------------------------------------------------------------------------
// barycentric_texel_address
// Barycentric weight and texel address pipeline for one configured triangle.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : register writes (index, data), always ready. Write only while
//            no request is in flight.
//   s_*    : fragment requests (frag_x, frag_y), valid/ready.
//   m_*    : results (x, y passed through, texel index, visible flag).
// Pipeline: 31 register stages (the request is registered at
//   acceptance), 18 stages of which are a one-bit-per-stage restoring
//   divider for the alpha and beta weights.
// Throughput: one request per cycle while the result side takes one per cycle.
// Reset: aresetn clears the vertex and uv registers to zero, the window to
//   800 x 600, and all stage valid bits; no clearing pass is needed.
// Stall: a result held back by m_ready is parked in a skid register; the
//   pipeline freezes from the next cycle and s_ready drops until the parked
//   result is taken. Nothing is lost or repeated.
// A zero-area triangle yields texel index 0 and visible 0.
// ----------------------------------------------------------------------------
module barycentric_texel_address #(
    parameter int TEX_WIDTH  = bta_pkg::TEX_WIDTH_DEF,
    parameter int TEX_HEIGHT = bta_pkg::TEX_HEIGHT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [3:0]                         cfg_index,
    input  logic [31:0]                        cfg_data,
    // requests
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [bta_pkg::FRAG_W-1:0]  s_frag_x,
    input  logic signed [bta_pkg::FRAG_W-1:0]  s_frag_y,
    // results
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bta_pkg::FRAG_W-1:0]  m_out_x,
    output logic signed [bta_pkg::FRAG_W-1:0]  m_out_y,
    output logic [bta_pkg::IDX_W-1:0]          m_texel_index,
    output logic                               m_visible
);

    localparam int N_ST = 31;
    localparam int DIV_LAST = 4 + bta_pkg::DIV_STEPS;   // stage of last divider step

    // texture coordinate scaling widths
    localparam int TW_W   = $clog2(TEX_WIDTH + 1);
    localparam int TH_W   = $clog2(TEX_HEIGHT + 1);
    localparam int MAGX_W = bta_pkg::UV_W + 1 + TW_W;
    localparam int MAGY_W = bta_pkg::UV_W + 1 + TH_W;
    localparam int XX_W   = MAGX_W - 12;
    localparam int XY_W   = MAGY_W - 12;
    localparam int K_X    = XX_W + TW_W;
    localparam int K_Y    = XY_W + TH_W;
    localparam int RCP_X  = ((1 << K_X) + TEX_WIDTH - 1) / TEX_WIDTH;
    localparam int RCP_Y  = ((1 << K_Y) + TEX_HEIGHT - 1) / TEX_HEIGHT;
    localparam int PQX_W  = XX_W + K_X + 1;
    localparam int PQY_W  = XY_W + K_Y + 1;
    localparam int ADR_W  = TW_W + TH_W + 1;

    typedef struct packed {
        logic signed [bta_pkg::FRAG_W-1:0] px;
        logic signed [bta_pkg::FRAG_W-1:0] py;
        logic                              vis;
        logic                              neg_a;
        logic                              neg_b;
        logic                              ovf_a;
        logic                              ovf_b;
    } side_t;

    typedef struct packed {
        logic signed [bta_pkg::FRAG_W-1:0] x;
        logic signed [bta_pkg::FRAG_W-1:0] y;
        logic [bta_pkg::IDX_W-1:0]         index;
        logic                              vis;
    } result_t;

    // configuration registers
    logic [31:0]               vertex_a_reg, vertex_b_reg, vertex_c_reg;
    logic [31:0]               uv_a_reg, uv_b_reg, uv_c_reg;
    logic [bta_pkg::WIN_W-1:0] win_w_reg, win_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_a_reg <= '0;
            vertex_b_reg <= '0;
            vertex_c_reg <= '0;
            uv_a_reg     <= '0;
            uv_b_reg     <= '0;
            uv_c_reg     <= '0;
            win_w_reg    <= bta_pkg::WIN_W_RESET;
            win_h_reg    <= bta_pkg::WIN_H_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bta_pkg::REG_VERTEX_A:   vertex_a_reg <= cfg_data;
                bta_pkg::REG_VERTEX_B:   vertex_b_reg <= cfg_data;
                bta_pkg::REG_VERTEX_C:   vertex_c_reg <= cfg_data;
                bta_pkg::REG_UV_A:       uv_a_reg     <= cfg_data;
                bta_pkg::REG_UV_B:       uv_b_reg     <= cfg_data;
                bta_pkg::REG_UV_C:       uv_c_reg     <= cfg_data;
                bta_pkg::REG_WIN_WIDTH:  win_w_reg    <= cfg_data[bta_pkg::WIN_W-1:0];
                bta_pkg::REG_WIN_HEIGHT: win_h_reg    <= cfg_data[bta_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // vertex and uv fields
    logic signed [bta_pkg::COORD_W-1:0] ax, ay, bx, by, cx, cy;
    logic signed [bta_pkg::UV_W-1:0]    ua, ub, uc, va, vb, vc;

    assign ax = $signed(vertex_a_reg[15:0]);
    assign ay = $signed(vertex_a_reg[31:16]);
    assign bx = $signed(vertex_b_reg[15:0]);
    assign by = $signed(vertex_b_reg[31:16]);
    assign cx = $signed(vertex_c_reg[15:0]);
    assign cy = $signed(vertex_c_reg[31:16]);
    assign ua = $signed(uv_a_reg[15:0]);
    assign va = $signed(uv_a_reg[31:16]);
    assign ub = $signed(uv_b_reg[15:0]);
    assign vb = $signed(uv_b_reg[31:16]);
    assign uc = $signed(uv_c_reg[15:0]);
    assign vc = $signed(uv_c_reg[31:16]);

    // triangle area: difference, product, area and magnitude registers behind the vertex registers
    logic signed [bta_pkg::DIF_W-1:0]  cax_reg, cay_reg, bax_reg, bay_reg;
    logic signed [bta_pkg::PROD_W-1:0] ap1_reg, ap2_reg;
    logic signed [bta_pkg::NUM_W-1:0]  area_reg;
    logic [bta_pkg::NUM_W-1:0]         area_abs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cax_reg      <= '0;
            cay_reg      <= '0;
            bax_reg      <= '0;
            bay_reg      <= '0;
            ap1_reg      <= '0;
            ap2_reg      <= '0;
            area_reg     <= '0;
            area_abs_reg <= '0;
        end else begin
            cax_reg      <= bta_pkg::DIF_W'(cx) - bta_pkg::DIF_W'(ax);
            cay_reg      <= bta_pkg::DIF_W'(cy) - bta_pkg::DIF_W'(ay);
            bax_reg      <= bta_pkg::DIF_W'(bx) - bta_pkg::DIF_W'(ax);
            bay_reg      <= bta_pkg::DIF_W'(by) - bta_pkg::DIF_W'(ay);
            ap1_reg      <= bta_pkg::PROD_W'(cax_reg) * bta_pkg::PROD_W'(bay_reg);
            ap2_reg      <= bta_pkg::PROD_W'(cay_reg) * bta_pkg::PROD_W'(bax_reg);
            area_reg     <= bta_pkg::NUM_W'(ap1_reg) - bta_pkg::NUM_W'(ap2_reg);
            area_abs_reg <= area_reg[bta_pkg::NUM_W-1] ? bta_pkg::NUM_W'(-area_reg)
                                                       : bta_pkg::NUM_W'(area_reg);
        end
    end

    // pipeline control: whole pipe advances unless a result is parked
    logic            pipe_en;
    logic [N_ST-1:0] valid_reg;
    logic            skid_valid_reg;
    result_t         skid_reg;
    result_t         result_next;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[N_ST-2:0], s_valid};
        end
    end

    side_t side_reg [N_ST];

    // stage 1 window test
    logic vis_next;
    always_comb begin
        vis_next = !side_reg[0].px[bta_pkg::FRAG_W-1]
                && ({1'b0, side_reg[0].px[bta_pkg::FRAG_W-2:0]} < win_w_reg)
                && !side_reg[0].py[bta_pkg::FRAG_W-1]
                && ({1'b0, side_reg[0].py[bta_pkg::FRAG_W-2:0]} < win_h_reg);
    end

    // stage 4 magnitudes, signs and range flags
    logic signed [bta_pkg::NUM_W-1:0] na_reg, nb_reg;
    logic [bta_pkg::NUM_W-1:0]    mag_a, mag_b;
    logic                         ovf_a_next, ovf_b_next;

    always_comb begin
        mag_a = na_reg[bta_pkg::NUM_W-1] ? bta_pkg::NUM_W'(-na_reg) : bta_pkg::NUM_W'(na_reg);
        mag_b = nb_reg[bta_pkg::NUM_W-1] ? bta_pkg::NUM_W'(-nb_reg) : bta_pkg::NUM_W'(nb_reg);
        ovf_a_next = {2'b00, mag_a} >= {area_abs_reg, 2'b00};
        ovf_b_next = {2'b00, mag_b} >= {area_abs_reg, 2'b00};
    end

    // sideband travelling with each request
    side_t side_next [N_ST];

    always_comb begin
        side_next[0] = '{px: s_frag_x, py: s_frag_y, vis: 1'b0,
                         neg_a: 1'b0, neg_b: 1'b0, ovf_a: 1'b0, ovf_b: 1'b0};
        for (int k = 1; k < N_ST; k++) begin
            side_next[k] = side_reg[k-1];
        end
        side_next[1].vis   = vis_next;
        side_next[4].neg_a = na_reg[bta_pkg::NUM_W-1] ^ area_reg[bta_pkg::NUM_W-1];
        side_next[4].neg_b = nb_reg[bta_pkg::NUM_W-1] ^ area_reg[bta_pkg::NUM_W-1];
        side_next[4].ovf_a = ovf_a_next;
        side_next[4].ovf_b = ovf_b_next;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < N_ST; k++) begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // stages 1 to 3: edge functions for alpha and beta
    logic signed [bta_pkg::DIF_W-1:0]  cpx_reg, bpy_reg, cpy_reg, bpx_reg, pay_reg, pax_reg;
    logic signed [bta_pkg::PROD_W-1:0] m1_reg, m2_reg, m3_reg, m4_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cpx_reg <= bta_pkg::DIF_W'(cx) - bta_pkg::DIF_W'(side_reg[0].px);
            bpy_reg <= bta_pkg::DIF_W'(by) - bta_pkg::DIF_W'(side_reg[0].py);
            cpy_reg <= bta_pkg::DIF_W'(cy) - bta_pkg::DIF_W'(side_reg[0].py);
            bpx_reg <= bta_pkg::DIF_W'(bx) - bta_pkg::DIF_W'(side_reg[0].px);
            pay_reg <= bta_pkg::DIF_W'(side_reg[0].py) - bta_pkg::DIF_W'(ay);
            pax_reg <= bta_pkg::DIF_W'(side_reg[0].px) - bta_pkg::DIF_W'(ax);
            m1_reg  <= bta_pkg::PROD_W'(cpx_reg) * bta_pkg::PROD_W'(bpy_reg);
            m2_reg  <= bta_pkg::PROD_W'(cpy_reg) * bta_pkg::PROD_W'(bpx_reg);
            m3_reg  <= bta_pkg::PROD_W'(cax_reg) * bta_pkg::PROD_W'(pay_reg);
            m4_reg  <= bta_pkg::PROD_W'(cay_reg) * bta_pkg::PROD_W'(pax_reg);
            na_reg  <= bta_pkg::NUM_W'(m1_reg) - bta_pkg::NUM_W'(m2_reg);
            nb_reg  <= bta_pkg::NUM_W'(m3_reg) - bta_pkg::NUM_W'(m4_reg);
        end
    end

    // stage 4: divider lane setup, dividend is magnitude times 2^16
    bta_pkg::div_lane_t lane_a0_reg, lane_b0_reg;
    bta_pkg::div_lane_t lane_a [bta_pkg::DIV_STEPS+1];
    bta_pkg::div_lane_t lane_b [bta_pkg::DIV_STEPS+1];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            lane_a0_reg <= '{rem: bta_pkg::REM_W'(mag_a >> 2), quo: '0, low: mag_a[1:0]};
            lane_b0_reg <= '{rem: bta_pkg::REM_W'(mag_b >> 2), quo: '0, low: mag_b[1:0]};
        end
    end

    assign lane_a[0] = lane_a0_reg;
    assign lane_b[0] = lane_b0_reg;

    // stages 5 to 22: one quotient bit per stage
    for (genvar j = 0; j < bta_pkg::DIV_STEPS; j++) begin : g_div
        bta_div_step u_step (
            .aclk       (aclk),
            .en         (pipe_en),
            .divisor    (area_abs_reg),
            .lane_a_in  (lane_a[j]),
            .lane_b_in  (lane_b[j]),
            .lane_a_out (lane_a[j+1]),
            .lane_b_out (lane_b[j+1])
        );
    end

    // stages 23 to 26: weights and interpolation
    logic signed [bta_pkg::W_W-1:0]   wa_reg, wb_reg, wa2_reg, wb2_reg, wc_reg;
    logic signed [bta_pkg::UVP_W-1:0] pua_reg, pub_reg, puc_reg, pva_reg, pvb_reg, pvc_reg;
    logic signed [bta_pkg::UV_W-1:0]  uq_reg, vq_reg;
    logic signed [bta_pkg::W_W+1:0]   wc_next;
    logic signed [bta_pkg::SUM_W-1:0] su_next, sv_next;

    always_comb begin
        wc_next = (bta_pkg::W_W+2)'(65536) - (bta_pkg::W_W+2)'(wa_reg)
                - (bta_pkg::W_W+2)'(wb_reg);
        su_next = bta_pkg::SUM_W'(pua_reg) + bta_pkg::SUM_W'(pub_reg)
                + bta_pkg::SUM_W'(puc_reg);
        sv_next = bta_pkg::SUM_W'(pva_reg) + bta_pkg::SUM_W'(pvb_reg)
                + bta_pkg::SUM_W'(pvc_reg);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            wa_reg  <= bta_pkg::sat_weight(lane_a[bta_pkg::DIV_STEPS].quo,
                                           side_reg[DIV_LAST].neg_a, side_reg[DIV_LAST].ovf_a);
            wb_reg  <= bta_pkg::sat_weight(lane_b[bta_pkg::DIV_STEPS].quo,
                                           side_reg[DIV_LAST].neg_b, side_reg[DIV_LAST].ovf_b);
            wa2_reg <= wa_reg;
            wb2_reg <= wb_reg;
            wc_reg  <= bta_pkg::sat_gamma(wc_next);
            pua_reg <= bta_pkg::UVP_W'(ua) * bta_pkg::UVP_W'(wa2_reg);
            pub_reg <= bta_pkg::UVP_W'(ub) * bta_pkg::UVP_W'(wb2_reg);
            puc_reg <= bta_pkg::UVP_W'(uc) * bta_pkg::UVP_W'(wc_reg);
            pva_reg <= bta_pkg::UVP_W'(va) * bta_pkg::UVP_W'(wa2_reg);
            pvb_reg <= bta_pkg::UVP_W'(vb) * bta_pkg::UVP_W'(wb2_reg);
            pvc_reg <= bta_pkg::UVP_W'(vc) * bta_pkg::UVP_W'(wc_reg);
            uq_reg  <= bta_pkg::scale_uv(su_next);
            vq_reg  <= bta_pkg::scale_uv(sv_next);
        end
    end

    // stages 27 to 30: scale by texture size, wrap, form the address
    logic [bta_pkg::UV_W:0] abs_u, abs_v;
    logic [MAGX_W-1:0]      magx;
    logic [MAGY_W-1:0]      magy;
    logic [XX_W-1:0]        xx_reg, xx2_reg, qx_reg;
    logic [XY_W-1:0]        xy_reg, xy2_reg, qy_reg;
    logic [PQX_W-1:0]       pqx;
    logic [PQY_W-1:0]       pqy;
    logic [TW_W-1:0]        tx_reg;
    logic [TH_W-1:0]        ty_reg;
    logic [ADR_W-1:0]       addr_reg;

    always_comb begin
        abs_u = uq_reg[bta_pkg::UV_W-1] ? (bta_pkg::UV_W+1)'(-(bta_pkg::UV_W+1)'(uq_reg))
                                        : (bta_pkg::UV_W+1)'(uq_reg);
        abs_v = vq_reg[bta_pkg::UV_W-1] ? (bta_pkg::UV_W+1)'(-(bta_pkg::UV_W+1)'(vq_reg))
                                        : (bta_pkg::UV_W+1)'(vq_reg);
        magx  = MAGX_W'(abs_u) * MAGX_W'(TEX_WIDTH);
        magy  = MAGY_W'(abs_v) * MAGY_W'(TEX_HEIGHT);
        pqx   = PQX_W'(xx_reg) * PQX_W'(RCP_X);
        pqy   = PQY_W'(xy_reg) * PQY_W'(RCP_Y);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            xx_reg   <= magx[MAGX_W-1:12];
            xy_reg   <= magy[MAGY_W-1:12];
            xx2_reg  <= xx_reg;
            xy2_reg  <= xy_reg;
            qx_reg   <= XX_W'(pqx >> K_X);
            qy_reg   <= XY_W'(pqy >> K_Y);
            tx_reg   <= TW_W'(xx2_reg - XX_W'(qx_reg * XX_W'(TEX_WIDTH)));
            ty_reg   <= TH_W'(xy2_reg - XY_W'(qy_reg * XY_W'(TEX_HEIGHT)));
            addr_reg <= ADR_W'(tx_reg) + ADR_W'(ty_reg) * ADR_W'(TEX_WIDTH);
        end
    end

    // result assembly, zero-area triangle forced to index 0, not visible
    always_comb begin
        result_next.x     = side_reg[N_ST-1].px;
        result_next.y     = side_reg[N_ST-1].py;
        result_next.index = (area_reg == '0) ? '0 : bta_pkg::IDX_W'(addr_reg);
        result_next.vis   = side_reg[N_ST-1].vis && (area_reg != '0);
    end

    // skid register for a result the receiver does not take
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (valid_reg[N_ST-1] && !m_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            skid_reg <= result_next;
        end
    end

    result_t result_out;
    assign result_out    = skid_valid_reg ? skid_reg : result_next;
    assign m_valid       = skid_valid_reg || valid_reg[N_ST-1];
    assign m_out_x       = result_out.x;
    assign m_out_y       = result_out.y;
    assign m_texel_index = result_out.index;
    assign m_visible     = result_out.vis;

    // checks
    a_vis_needs_area: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visible |-> area_reg != '0)
        else $error("visible result with zero-area triangle");

    a_zero_area_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (area_reg == '0) |-> m_texel_index == '0)
        else $error("nonzero texel index for zero-area triangle");

    a_vis_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visible |-> !m_out_x[bta_pkg::FRAG_W-1] && !m_out_y[bta_pkg::FRAG_W-1])
        else $error("visible result with negative coordinate");

    a_skid_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(valid_reg[N_ST-1] && !m_ready))
        else $error("skid register filled without a stalled result");

    a_park_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |=> $stable(valid_reg) || !$past(skid_valid_reg))
        else $error("pipeline moved while a result was parked");

endmodule
